### rtl/etp_pkg.sv
// package: shared constants and types for the edge trace locality profiler
`timescale 1ns / 1ps
`default_nettype none
package etp_pkg;
    localparam int MAX_VERTICES_DEF = 65536;
    localparam int LANE_WIDTH_DEF   = 16;

    localparam int VTX_W    = 16;
    localparam int EID_W    = 32;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 64;
    localparam int VCNT_W   = 17;
    localparam int WIN_W    = 16;
    localparam int PCT_W    = 23;
    localparam int CFG_W    = 17;
    localparam int DIV_N_W  = 64;
    localparam int DIV_D_W  = 32;
    localparam int DIV_C_W  = 7;

    localparam logic [CNT_W-1:0] PACK_SAT = '1;
    localparam logic [6:0]       PCT_SCALE = 7'd100;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd4096;
    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 17'd1;

    typedef enum logic {
        REG_VERTEX_COUNT = 1'b0,
        REG_REUSE_WINDOW = 1'b1
    } t_reg_idx;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_DSET   = 6'b001000,
        S_DWAIT  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        OP_VS   = 3'd0,
        OP_GS   = 3'd1,
        OP_DS   = 3'd2,
        OP_PACK = 3'd3,
        OP_VP   = 3'd4,
        OP_GP   = 3'd5,
        OP_DP   = 3'd6
    } t_div_op;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

### rtl/etp_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module etp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/etp_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module etp_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire etp_pkg::t_div_req  i_req,
    output etp_pkg::t_div_rsp       o_rsp
);
    import etp_pkg::*;

    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W:0]   r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_C_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   w_sh;
    logic               w_ge;

    assign w_sh = {r_rem[DIV_D_W-1:0], r_q[DIV_N_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
                r_q   <= {r_q[DIV_N_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_C_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule
`default_nettype wire

### rtl/edge_trace_locality_profiler.sv
// top level: edge trace locality profiler
//  channel   | handshake         | payload
//  edge in   | i_valid / o_ready | edge_id, source, target, final flag
//  summary   | o_valid / i_ready | counts, strides, packing, percentages, fault
//  config    | i_cfg_we          | i_cfg_index, i_cfg_data
// an edge is handled as a lane table read, then modify and write back
// a final edge adds 7 divisions in sequence on one shared divider
// then a lane table clearing pass over all LANES entries; the same pass follows reset
// o_ready is low during the pass and while an item is in work
// a pending summary only stalls the next final edge
`timescale 1ns / 1ps
`default_nettype none
module edge_trace_locality_profiler #(
    parameter int MAX_VERTICES = etp_pkg::MAX_VERTICES_DEF,
    parameter int LANE_WIDTH   = etp_pkg::LANE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [etp_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [etp_pkg::EID_W-1:0]     i_edge_id,
    input  wire logic [etp_pkg::VTX_W-1:0]     i_source_vertex,
    input  wire logic [etp_pkg::VTX_W-1:0]     i_target_vertex,
    input  wire logic                          i_final_edge,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [etp_pkg::CNT_W-1:0]          o_time_hits,
    output logic [etp_pkg::CNT_W-1:0]          o_local_hits,
    output logic [etp_pkg::CNT_W-1:0]          o_misses,
    output logic [etp_pkg::VTX_W-1:0]          o_vertex_stride,
    output logic [etp_pkg::VTX_W-1:0]          o_global_stride,
    output logic [etp_pkg::VTX_W-1:0]          o_diagonal_stride,
    output logic [etp_pkg::CNT_W-1:0]          o_packing,
    output logic [etp_pkg::PCT_W-1:0]          o_vertex_pack_pct,
    output logic [etp_pkg::PCT_W-1:0]          o_global_pack_pct,
    output logic [etp_pkg::PCT_W-1:0]          o_diagonal_pack_pct,
    output logic                               o_divide_fault
);
    import etp_pkg::*;

    localparam int LANES  = (MAX_VERTICES + LANE_WIDTH - 1) / LANE_WIDTH;
    localparam int AW     = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int POS_W  = $clog2(LANE_WIDTH);
    localparam int ENT_W  = 1 + EID_W + LANE_WIDTH;

    t_state r_state;
    t_div_op r_op;

    logic [VCNT_W-1:0] r_vertex_count;
    logic [WIN_W-1:0]  r_reuse_window;

    logic [EID_W-1:0] r_eid;
    logic [VTX_W-1:0] r_src;
    logic [VTX_W-1:0] r_dst;
    logic             r_fin;

    logic [VTX_W-1:0] r_prev_src;
    logic [VTX_W-1:0] r_prev_dst;
    logic [CNT_W-1:0] r_edge_cnt;
    logic [CNT_W-1:0] r_time_cnt;
    logic [CNT_W-1:0] r_local_cnt;
    logic [CNT_W-1:0] r_same_cnt;
    logic [SUM_W-1:0] r_vsum;
    logic [SUM_W-1:0] r_gsum;
    logic [SUM_W-1:0] r_dsum;

    logic [AW-1:0] r_clr_addr;

    logic [VTX_W-1:0] r_vs, r_gs, r_ds;
    logic [CNT_W-1:0] r_pack;
    logic [PCT_W-1:0] r_vp, r_gp, r_dp;
    logic             r_fault;

    logic r_out_valid;

    // lane table access
    logic [VTX_W-1:0]      w_in_lane;
    logic [VTX_W-1:0]      w_lane;
    logic [POS_W-1:0]      w_pos;
    logic [LANE_WIDTH-1:0] w_bit;
    logic                  w_in_range;
    logic [ENT_W-1:0]      w_rdata;
    logic                  w_ent_valid;
    logic [EID_W-1:0]      w_ent_stamp;
    logic [LANE_WIDTH-1:0] w_ent_mask;
    logic                  w_miss;
    logic                  w_thit;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [ENT_W-1:0]      w_wdata;

    assign w_in_lane  = VTX_W'(i_target_vertex / LANE_WIDTH);
    assign w_lane     = VTX_W'(r_dst / LANE_WIDTH);
    assign w_pos      = POS_W'(r_dst % LANE_WIDTH);
    assign w_bit      = LANE_WIDTH'(1) << w_pos;
    assign w_in_range = {8'd0, w_lane} < 24'(LANES);

    assign {w_ent_valid, w_ent_stamp, w_ent_mask} = w_rdata;
    assign w_miss = !w_ent_valid || ((r_eid - w_ent_stamp) > {16'd0, r_reuse_window});
    assign w_thit = !w_miss && ((w_ent_mask & w_bit) != '0);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_UPDATE: begin
                w_we    = w_in_range;
                w_waddr = AW'(w_lane);
                if (w_miss) begin
                    w_wdata = {1'b1, r_eid, w_bit};
                end else begin
                    w_wdata = {1'b1, r_eid, w_ent_mask | w_bit};
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    etp_ram #(
        .WIDTH(ENT_W),
        .DEPTH(LANES),
        .AW   (AW)
    ) u_lane_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(AW'(w_in_lane)),
        .o_rdata(w_rdata)
    );

    // distances
    logic [VTX_W-1:0] w_tstride;
    logic [VTX_W-1:0] w_dstride;
    assign w_tstride = (r_prev_dst > r_dst) ? (r_prev_dst - r_dst) : (r_dst - r_prev_dst);
    assign w_dstride = (r_src > r_dst) ? (r_src - r_dst) : (r_dst - r_src);

    // divider sequencing
    t_div_req w_req;
    t_div_rsp w_rsp;
    logic [DIV_N_W-1:0] w_dvd;
    logic [DIV_D_W-1:0] w_dvs;
    logic               w_last_op;
    t_div_op            w_next_op;
    logic [2*VCNT_W-1:0] w_vsq;

    assign w_vsq = r_vertex_count * r_vertex_count;

    always_comb begin
        w_dvd     = '0;
        w_dvs     = r_edge_cnt;
        w_next_op = OP_VS;
        case (r_op)
            OP_VS: begin
                w_dvd = r_vsum; w_dvs = r_same_cnt; w_next_op = OP_GS;
            end
            OP_GS: begin
                w_dvd = r_gsum; w_next_op = OP_DS;
            end
            OP_DS: begin
                w_dvd = r_dsum; w_next_op = OP_PACK;
            end
            OP_PACK: begin
                w_dvd = DIV_N_W'(w_vsq); w_next_op = OP_VP;
            end
            OP_VP: begin
                w_dvd = DIV_N_W'(r_vs) * DIV_N_W'(PCT_SCALE);
                w_dvs = r_pack; w_next_op = OP_GP;
            end
            OP_GP: begin
                w_dvd = DIV_N_W'(r_gs) * DIV_N_W'(PCT_SCALE);
                w_dvs = r_pack; w_next_op = OP_DP;
            end
            OP_DP: begin
                w_dvd = DIV_N_W'(r_ds) * DIV_N_W'(PCT_SCALE);
                w_dvs = r_pack; w_next_op = OP_VS;
            end
            default: begin
                w_dvd = '0;
            end
        endcase
    end

    assign w_last_op      = (r_op == OP_DP);
    assign w_req.start    = (r_state == S_DSET) && (w_dvs != '0);
    assign w_req.dividend = w_dvd;
    assign w_req.divisor  = w_dvs;

    etp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    logic [DIV_N_W-1:0] w_q;
    logic               w_store;
    assign w_store = ((r_state == S_DSET) && (w_dvs == '0))
                  || ((r_state == S_DWAIT) && w_rsp.done);
    assign w_q = (r_state == S_DSET) ? '0 : w_rsp.quotient;

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
            r_reuse_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                REG_REUSE_WINDOW: r_reuse_window <= i_cfg_data[WIN_W-1:0];
                default: r_reuse_window <= r_reuse_window;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_eid <= i_edge_id;
            r_src <= i_source_vertex;
            r_dst <= i_target_vertex;
            r_fin <= i_final_edge;
        end
        if (w_store) begin
            case (r_op)
                OP_VS: r_vs <= w_q[VTX_W-1:0];
                OP_GS: r_gs <= w_q[VTX_W-1:0];
                OP_DS: r_ds <= w_q[VTX_W-1:0];
                OP_PACK: r_pack <= (w_q[DIV_N_W-1:CNT_W] != '0) ? PACK_SAT : w_q[CNT_W-1:0];
                OP_VP: r_vp <= w_q[PCT_W-1:0];
                OP_GP: r_gp <= w_q[PCT_W-1:0];
                OP_DP: r_dp <= w_q[PCT_W-1:0];
                default: r_dp <= r_dp;
            endcase
        end
        if ((r_state == S_OUT) && !r_out_valid) begin
            o_time_hits         <= r_time_cnt;
            o_local_hits        <= r_local_cnt;
            o_misses            <= r_edge_cnt - r_time_cnt - r_local_cnt;
            o_vertex_stride     <= r_vs;
            o_global_stride     <= r_gs;
            o_diagonal_stride   <= r_ds;
            o_packing           <= r_pack;
            o_vertex_pack_pct   <= r_vp;
            o_global_pack_pct   <= r_gp;
            o_diagonal_pack_pct <= r_dp;
            o_divide_fault      <= r_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_op        <= OP_VS;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_fault     <= 1'b0;
            r_prev_src  <= '0;
            r_prev_dst  <= '0;
            r_edge_cnt  <= '0;
            r_time_cnt  <= '0;
            r_local_cnt <= '0;
            r_same_cnt  <= '0;
            r_vsum      <= '0;
            r_gsum      <= '0;
            r_dsum      <= '0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(LANES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (w_in_range && !w_miss) begin
                        if (w_thit) begin
                            r_time_cnt <= r_time_cnt + 1'b1;
                        end else begin
                            r_local_cnt <= r_local_cnt + 1'b1;
                        end
                    end
                    if (r_src == r_prev_src) begin
                        r_vsum     <= r_vsum + SUM_W'(w_tstride);
                        r_same_cnt <= r_same_cnt + 1'b1;
                    end
                    r_gsum     <= r_gsum + SUM_W'(w_tstride);
                    r_dsum     <= r_dsum + SUM_W'(w_dstride);
                    r_prev_src <= r_src;
                    r_prev_dst <= r_dst;
                    r_edge_cnt <= r_edge_cnt + 1'b1;
                    r_op       <= OP_VS;
                    r_fault    <= 1'b0;
                    r_state    <= r_fin ? S_DSET : S_IDLE;
                end
                S_DSET: begin
                    if (w_dvs == '0) begin
                        r_fault <= 1'b1;
                        r_op    <= w_next_op;
                        r_state <= w_last_op ? S_OUT : S_DSET;
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (w_rsp.done) begin
                        r_op    <= w_next_op;
                        r_state <= w_last_op ? S_OUT : S_DSET;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_prev_src  <= '0;
                        r_prev_dst  <= '0;
                        r_edge_cnt  <= '0;
                        r_time_cnt  <= '0;
                        r_local_cnt <= '0;
                        r_same_cnt  <= '0;
                        r_vsum      <= '0;
                        r_gsum      <= '0;
                        r_dsum      <= '0;
                        r_clr_addr  <= '0;
                        r_state     <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
endmodule
`default_nettype wire

### rtl/etp_chk.sv
// port checker for the edge trace locality profiler, with its bind
`timescale 1ns / 1ps
`default_nettype none
module etp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_time_hits,
    input wire logic [31:0] o_packing,
    input wire logic [22:0] o_vertex_pack_pct,
    input wire logic        o_divide_fault
);
    // summary holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_time_hits) && $stable(o_packing))
        else $error("summary changed while stalled");

    // one item in work at a time
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item accepted back to back");

    // lane table clear after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("ready during clearing pass");

    // zero packing is a fault with zero percentages
    a_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packing == 32'd0 |-> o_divide_fault && o_vertex_pack_pct == 23'd0)
        else $error("zero packing without fault");
endmodule

bind edge_trace_locality_profiler etp_chk u_etp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_time_hits      (o_time_hits),
    .o_packing        (o_packing),
    .o_vertex_pack_pct(o_vertex_pack_pct),
    .o_divide_fault   (o_divide_fault)
);
`default_nettype wire

### tb/tb.sv
// testbench for the edge trace locality profiler: directed and random traces vs a predictor
`timescale 1ns / 1ps
module tb;
    import etp_pkg::*;

    localparam int LANE_CNT = 4096;
    localparam longint CYCLE_LIMIT = 64'd40000000;

    typedef struct packed {
        logic [31:0] time_hits;
        logic [31:0] local_hits;
        logic [31:0] misses;
        logic [15:0] vertex_stride;
        logic [15:0] global_stride;
        logic [15:0] diagonal_stride;
        logic [31:0] packing;
        logic [22:0] vertex_pack_pct;
        logic [22:0] global_pack_pct;
        logic [22:0] diagonal_pack_pct;
        logic        divide_fault;
    } t_summary;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [16:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_edge_id;
    logic [15:0] i_source_vertex;
    logic [15:0] i_target_vertex;
    logic        i_final_edge;
    logic        o_valid;
    logic        i_ready;
    t_summary    got;

    edge_trace_locality_profiler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_edge_id(i_edge_id), .i_source_vertex(i_source_vertex),
        .i_target_vertex(i_target_vertex), .i_final_edge(i_final_edge),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_time_hits(got.time_hits), .o_local_hits(got.local_hits),
        .o_misses(got.misses), .o_vertex_stride(got.vertex_stride),
        .o_global_stride(got.global_stride), .o_diagonal_stride(got.diagonal_stride),
        .o_packing(got.packing), .o_vertex_pack_pct(got.vertex_pack_pct),
        .o_global_pack_pct(got.global_pack_pct),
        .o_diagonal_pack_pct(got.diagonal_pack_pct), .o_divide_fault(got.divide_fault)
    );

    // predictor state
    bit          lane_ok [LANE_CNT];
    logic [31:0] lane_id [LANE_CNT];
    logic [15:0] lane_bits [LANE_CNT];
    logic [16:0] vcount;
    logic [15:0] window;
    logic [15:0] prev_src, prev_dst;
    logic [31:0] n_edges, n_time, n_local, n_same;
    logic [63:0] sum_vtx, sum_glob, sum_diag;

    t_summary    pending_summaries[$];
    int          errors;
    longint      cycles;
    logic [31:0] eid;
    int          gap_max;

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic clear_trace();
        for (int k = 0; k < LANE_CNT; k++) begin
            lane_ok[k] = 1'b0;
            lane_id[k] = '0;
            lane_bits[k] = '0;
        end
        prev_src = '0; prev_dst = '0;
        n_edges = '0; n_time = '0; n_local = '0; n_same = '0;
        sum_vtx = '0; sum_glob = '0; sum_diag = '0;
    endtask

    function automatic logic [15:0] absdiff(logic [15:0] a, logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [22:0] pack_pct(logic [15:0] s, logic [63:0] pk);
        logic [63:0] num;
        num = 64'(s) * 100;
        return (pk != 0) ? 23'(num / pk) : '0;
    endfunction

    task automatic profile_edge(logic [31:0] id, logic [15:0] src, logic [15:0] dst,
                                logic fin);
        int          ln;
        logic [15:0] bitm;
        logic [31:0] age;
        t_summary    s;
        logic [63:0] vs, gs, ds, pk, vc;
        logic        flt;
        ln = dst >> 4;
        bitm = 16'(1) << dst[3:0];
        age = id - lane_id[ln];
        if (!lane_ok[ln] || age > 32'(window)) begin
            lane_ok[ln] = 1'b1;
            lane_id[ln] = id;
            lane_bits[ln] = bitm;
        end else if ((lane_bits[ln] & bitm) != 0) begin
            n_time++;
            lane_id[ln] = id;
        end else begin
            n_local++;
            lane_id[ln] = id;
            lane_bits[ln] |= bitm;
        end
        if (src == prev_src) begin
            sum_vtx += absdiff(prev_dst, dst);
            n_same++;
        end
        sum_glob += absdiff(prev_dst, dst);
        sum_diag += absdiff(src, dst);
        prev_src = src;
        prev_dst = dst;
        n_edges++;
        if (!fin) return;
        flt = 1'b0; vs = 0; gs = 0; ds = 0; pk = 0;
        vc = 64'(vcount);
        if (n_same != 0) vs = sum_vtx / n_same;
        else flt = 1'b1;
        if (n_edges != 0) begin
            gs = sum_glob / n_edges;
            ds = sum_diag / n_edges;
            pk = (vc * vc) / n_edges;
            if (pk > 64'hFFFF_FFFF) pk = 64'hFFFF_FFFF;
        end else begin
            flt = 1'b1;
        end
        if (pk == 0) flt = 1'b1;
        s.time_hits = n_time;
        s.local_hits = n_local;
        s.misses = n_edges - n_time - n_local;
        s.vertex_stride = vs[15:0];
        s.global_stride = gs[15:0];
        s.diagonal_stride = ds[15:0];
        s.packing = pk[31:0];
        s.vertex_pack_pct = pack_pct(vs[15:0], pk);
        s.global_pack_pct = pack_pct(gs[15:0], pk);
        s.diagonal_pack_pct = pack_pct(ds[15:0], pk);
        s.divide_fault = flt;
        pending_summaries.push_back(s);
        clear_trace();
    endtask

    // receiver: stall pattern plus summary check
    always @(negedge i_clk) begin
        if (cycles % 300 < 150) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_summaries.size() == 0) begin
                $error("unexpected summary");
                errors++;
            end else begin
                t_summary e;
                e = pending_summaries.pop_front();
                if (got.time_hits !== e.time_hits) begin
                    $error("time_hits exp %0d got %0d", e.time_hits, got.time_hits); errors++;
                end
                if (got.local_hits !== e.local_hits) begin
                    $error("local_hits exp %0d got %0d", e.local_hits, got.local_hits); errors++;
                end
                if (got.misses !== e.misses) begin
                    $error("misses exp %0d got %0d", e.misses, got.misses); errors++;
                end
                if (got.vertex_stride !== e.vertex_stride) begin
                    $error("vertex_stride exp %0d got %0d", e.vertex_stride, got.vertex_stride);
                    errors++;
                end
                if (got.global_stride !== e.global_stride) begin
                    $error("global_stride exp %0d got %0d", e.global_stride, got.global_stride);
                    errors++;
                end
                if (got.diagonal_stride !== e.diagonal_stride) begin
                    $error("diagonal_stride exp %0d got %0d", e.diagonal_stride,
                           got.diagonal_stride);
                    errors++;
                end
                if (got.packing !== e.packing) begin
                    $error("packing exp %0d got %0d", e.packing, got.packing); errors++;
                end
                if (got.vertex_pack_pct !== e.vertex_pack_pct) begin
                    $error("vertex_pack_pct exp %0d got %0d", e.vertex_pack_pct,
                           got.vertex_pack_pct);
                    errors++;
                end
                if (got.global_pack_pct !== e.global_pack_pct) begin
                    $error("global_pack_pct exp %0d got %0d", e.global_pack_pct,
                           got.global_pack_pct);
                    errors++;
                end
                if (got.diagonal_pack_pct !== e.diagonal_pack_pct) begin
                    $error("diagonal_pack_pct exp %0d got %0d", e.diagonal_pack_pct,
                           got.diagonal_pack_pct);
                    errors++;
                end
                if (got.divide_fault !== e.divide_fault) begin
                    $error("divide_fault exp %0d got %0d", e.divide_fault, got.divide_fault);
                    errors++;
                end
            end
        end
    end

    task automatic send_edge(logic [31:0] id, logic [15:0] src, logic [15:0] dst, logic fin);
        i_valid <= 1'b1;
        i_edge_id <= id;
        i_source_vertex <= src;
        i_target_vertex <= dst;
        i_final_edge <= fin;
        do @(posedge i_clk); while (!o_ready);
        profile_edge(id, src, dst, fin);
        @(negedge i_clk);
        if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_summaries.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [16:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_VERTEX_COUNT) vcount = val;
        else window = val[15:0];
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        gap_max = 0;
        eid = 32'd0;
        send_edge(eid, 16'd0, 16'd0, 1'b0);
        send_edge(eid + 1, 16'd0, 16'd0, 1'b0);
        send_edge(eid + 2, 16'd0, 16'd1, 1'b0);
        send_edge(eid + 3, 16'hFFFF, 16'hFFFF, 1'b0);
        send_edge(eid + 4, 16'hFFFF, 16'hFFF0, 1'b0);
        send_edge(32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 1'b0);
        send_edge(32'd10, 16'hAAAA, 16'h5555, 1'b1);
        drain();
        // single edge, no same-source pair, vertex count 1 with one edge
        send_edge(32'd0, 16'd7, 16'd3, 1'b1);
        drain();
        // zero packing
        write_reg(REG_VERTEX_COUNT, 17'd0);
        send_edge(32'd0, 16'd0, 16'd9, 1'b0);
        send_edge(32'd1, 16'd0, 16'd9, 1'b1);
        drain();
        // packing just below saturation and stale lanes with zero window
        write_reg(REG_VERTEX_COUNT, 17'h1FFFF);
        write_reg(REG_REUSE_WINDOW, 17'd0);
        send_edge(32'd5, 16'd1, 16'd32, 1'b0);
        send_edge(32'd5, 16'd1, 16'd32, 1'b0);
        send_edge(32'd6, 16'd1, 16'd33, 1'b0);
        send_edge(32'd9, 16'd1, 16'd32, 1'b1);
        drain();
        write_reg(REG_REUSE_WINDOW, 17'hFFFF);
        write_reg(REG_VERTEX_COUNT, 17'd65536);
        send_edge(32'd0, 16'd2, 16'd100, 1'b0);
        send_edge(32'd65535, 16'd2, 16'd101, 1'b0);
        send_edge(32'd131071, 16'd2, 16'd100, 1'b1);
        drain();
    endtask

    task automatic test_random_traces(int n_items);
        int sent;
        int len;
        logic [15:0] base, src, dst;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_VERTEX_COUNT, 17'($urandom_range(0, 131071)));
                1: write_reg(REG_REUSE_WINDOW, 17'($urandom_range(0, 64)));
                2: write_reg(REG_VERTEX_COUNT, 17'($urandom_range(1, 300)));
                default: write_reg(REG_REUSE_WINDOW, 17'($urandom_range(0, 65535)));
            endcase
            gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            len = $urandom_range(1, 40);
            base = 16'($urandom);
            eid = $urandom;
            src = 16'($urandom_range(0, 3));
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) src = 16'($urandom);
                else if ($urandom_range(0, 2) == 0) src = 16'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) dst = 16'($urandom);
                else dst = base + 16'($urandom_range(0, 63));
                eid = eid + ($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 20));
                send_edge(eid, src, dst, k == len - 1);
                sent++;
            end
            drain();
        end
    endtask

    initial begin
        cycles = 0; errors = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = REG_VERTEX_COUNT; i_cfg_data = '0;
        i_valid = 1'b0; i_ready = 1'b0;
        i_edge_id = '0; i_source_vertex = '0; i_target_vertex = '0; i_final_edge = 1'b0;
        vcount = VCOUNT_RESET; window = WINDOW_RESET; gap_max = 0;
        clear_trace();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_traces(1500);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

### files.f
rtl/etp_pkg.sv
rtl/etp_ram.sv
rtl/etp_div.sv
rtl/edge_trace_locality_profiler.sv
rtl/etp_chk.sv
tb/tb.sv
